// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the bit field compress / expand block.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define ASSERT_AT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_AT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/bfce_pkg.sv =====
// Package for the bit field compress / expand block: widths, register
// indexes and the per-word control struct. Depends on nothing.
package bfce_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int WORD_W         = 64;
    localparam int VW_W           = 7;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_VALUE = 2'd2;

    localparam logic CMD_COMPRESS = 1'b0;
    localparam logic CMD_EXPAND   = 1'b1;

    typedef struct packed {
        logic valid;
        logic cmd;
        logic ok;
    } bfce_ctl_t;

endpackage

// ===== rtl/core/bit_field_compress_expand_top.sv =====
// Top level of the bit field compress / expand block: configuration
// registers, the chain of bit cells and the output skid stage.
// Depends on bfce_pkg, bfce_cell, bfce_skid.
//
// Input words arrive on s_tvalid/s_tready with the command in s_tuser
// (0 compress, 1 expand) and the word in s_tdata. Results leave on
// m_tvalid/m_tready: m_tdata carries the result, m_tuser the valid flag.
// Configuration: cfg_wr_en with cfg_index 0 value width, 1 fixed mask,
// 2 fixed value; write only while no word is in flight.
// Each word walks a row of DATA_WIDTH cells, one bit position per cell,
// then an output register; one word per cycle sustained while the skid
// stage is empty. The cell row advances as one and stops only while the
// skid stage is full: while a result waits, words keep entering until the
// next one reaches the skid stage; the row resumes in the cycle after the
// waiting word is taken.
// Reset empties the row and output, and sets width 64, mask 0, value 0.
module bit_field_compress_expand_top #(
    parameter int DATA_WIDTH = bfce_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bfce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfce_pkg::WORD_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bfce_pkg::WORD_W-1:0]      s_tdata,   // data_word
    input  logic                             s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bfce_pkg::WORD_W-1:0]      m_tdata,   // result_word
    output logic                             m_tuser    // result_valid
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [bfce_pkg::VW_W-1:0]   value_width_reg;
    logic [bfce_pkg::WORD_W-1:0] fixed_mask_reg;
    logic [bfce_pkg::WORD_W-1:0] fixed_value_reg;
    logic                        en;
    logic                        upper_ok;

    bfce_pkg::bfce_ctl_t         ctl_lane  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]       data_lane [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]       res_lane  [0:DATA_WIDTH];
    logic [CNT_W-1:0]            cnt_lane  [0:DATA_WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_width_reg <= bfce_pkg::VW_W'(64);
            fixed_mask_reg  <= '0;
            fixed_value_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bfce_pkg::REG_VALUE_WIDTH: value_width_reg <= cfg_wdata[bfce_pkg::VW_W-1:0];
                bfce_pkg::REG_FIXED_MASK:  fixed_mask_reg  <= cfg_wdata;
                bfce_pkg::REG_FIXED_VALUE: fixed_value_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    generate
        if (DATA_WIDTH < bfce_pkg::WORD_W) begin : g_upper
            assign upper_ok = ~|s_tdata[bfce_pkg::WORD_W-1:DATA_WIDTH];
        end else begin : g_full
            assign upper_ok = 1'b1;
        end
    endgenerate

    assign s_tready         = en;
    assign ctl_lane[0].valid = s_tvalid;
    assign ctl_lane[0].cmd   = s_tuser;
    assign ctl_lane[0].ok    = upper_ok;
    assign data_lane[0]      = s_tdata[DATA_WIDTH-1:0];
    assign res_lane[0]       = '0;
    assign cnt_lane[0]       = '0;

    generate
        for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
            bfce_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (i)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .en          (en),
                .value_width (value_width_reg),
                .mask_bit    (fixed_mask_reg[i]),
                .fixed_bit   (fixed_value_reg[i]),
                .ctl_in      (ctl_lane[i]),
                .data_in     (data_lane[i]),
                .res_in      (res_lane[i]),
                .cnt_in      (cnt_lane[i]),
                .ctl_out     (ctl_lane[i+1]),
                .data_out    (data_lane[i+1]),
                .res_out     (res_lane[i+1]),
                .cnt_out     (cnt_lane[i+1])
            );
        end
    endgenerate

    bfce_skid #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (ctl_lane[DATA_WIDTH]),
        .res_in   (res_lane[DATA_WIDTH]),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/bfce_cell.sv =====
// One bit-position cell of the compress / expand chain; handles bit INDEX
// of each word and passes the word on. Depends on bfce_pkg.
module bfce_cell #(
    parameter int DATA_WIDTH = bfce_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0,
    parameter int CNT_W      = $clog2(DATA_WIDTH + 1),
    parameter int IDX_W      = $clog2(DATA_WIDTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [bfce_pkg::VW_W-1:0]   value_width,
    input  logic                        mask_bit,
    input  logic                        fixed_bit,
    input  bfce_pkg::bfce_ctl_t         ctl_in,
    input  logic [DATA_WIDTH-1:0]       data_in,
    input  logic [DATA_WIDTH-1:0]       res_in,
    input  logic [CNT_W-1:0]            cnt_in,
    output bfce_pkg::bfce_ctl_t         ctl_out,
    output logic [DATA_WIDTH-1:0]       data_out,
    output logic [DATA_WIDTH-1:0]       res_out,
    output logic [CNT_W-1:0]            cnt_out
);

    bfce_pkg::bfce_ctl_t   ctl_reg, ctl_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  in_w, fix, var_bit, d;

    always_comb begin
        in_w    = value_width > bfce_pkg::VW_W'(INDEX);
        fix     = in_w & mask_bit;
        var_bit = in_w & ~mask_bit;
        d       = data_in[INDEX];
        ctl_next = ctl_in;
        res_next = res_in;
        cnt_next = cnt_in + CNT_W'(var_bit);
        if (ctl_in.cmd == bfce_pkg::CMD_COMPRESS) begin
            ctl_next.ok = ctl_in.ok & ~(~in_w & d) & ~(fix & (d ^ fixed_bit));
            if (var_bit) begin
                res_next[cnt_in[IDX_W-1:0]] = d;
            end
        end else begin
            if (var_bit) begin
                res_next[INDEX] = data_in[cnt_in[IDX_W-1:0]];
            end else if (fix) begin
                res_next[INDEX] = fixed_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_in;
            res_reg  <= res_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign data_out = data_reg;
    assign res_out  = res_reg;
    assign cnt_out  = cnt_reg;

endmodule

// ===== rtl/core/bfce_skid.sv =====
// Output register with skid stage: forms the result word from the chain end
// and parts the chain from the receiver. Depends on bfce_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bfce_skid #(
    parameter int DATA_WIDTH = bfce_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bfce_pkg::bfce_ctl_t           ctl_in,
    input  logic [DATA_WIDTH-1:0]         res_in,
    output logic                          en,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfce_pkg::WORD_W-1:0]   m_tdata,
    output logic                          m_tuser
);

    logic                        out_valid_reg, out_valid_next;
    logic [bfce_pkg::WORD_W-1:0] out_word_reg, out_word_next;
    logic                        out_flag_reg, out_flag_next;
    logic                        skid_valid_reg, skid_valid_next;
    logic [bfce_pkg::WORD_W-1:0] skid_word_reg, skid_word_next;
    logic                        skid_flag_reg, skid_flag_next;
    logic                        arrive, take, free;
    logic                        new_flag;
    logic [bfce_pkg::WORD_W-1:0] new_word;

    always_comb begin
        en       = ~skid_valid_reg;
        arrive   = en & ctl_in.valid;
        take     = out_valid_reg & m_tready;
        free     = ~out_valid_reg | take;
        new_flag = (ctl_in.cmd == bfce_pkg::CMD_EXPAND) | ctl_in.ok;
        new_word = new_flag ? bfce_pkg::WORD_W'(res_in) : '0;

        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_flag_next   = out_flag_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        skid_flag_next  = skid_flag_reg;
        if (skid_valid_reg) begin
            if (free) begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                out_flag_next   = skid_flag_reg;
                skid_valid_next = 1'b0;
            end
        end else if (arrive) begin
            if (free) begin
                out_valid_next = 1'b1;
                out_word_next  = new_word;
                out_flag_next  = new_flag;
            end else begin
                skid_valid_next = 1'b1;
                skid_word_next  = new_word;
                skid_flag_next  = new_flag;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        out_flag_reg  <= out_flag_next;
        skid_word_reg <= skid_word_next;
        skid_flag_reg <= skid_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_flag_reg;

    `ASSERT_AT(a_skid_needs_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `ASSERT_AT(a_invalid_is_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    `ASSERT_AT(a_skid_holds, aclk, aresetn, (skid_valid_reg && !m_tready) |=> skid_valid_reg)
    `ASSERT_AT_ALWAYS(a_reset_empty, aclk, $past(!aresetn) |-> (!m_tvalid && en))

endmodule

// ===== dv/tb_bit_field_compress_expand_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for bit_field_compress_expand_top: compress and expand
// words against an in-bench predictor under random stalls on both streams.
// Depends on bfce_pkg and the block's RTL only.
module tb_bit_field_compress_expand_top;

    localparam int DATA_W  = bfce_pkg::DATA_WIDTH_DEF;
    localparam int LATENCY = DATA_W + 1;
    localparam logic [bfce_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [bfce_pkg::WORD_W-1:0] word;
        logic                        flag;
    } result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [bfce_pkg::CFG_IDX_W-1:0] cfg_index = bfce_pkg::REG_VALUE_WIDTH;
    logic [bfce_pkg::WORD_W-1:0]    cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bfce_pkg::WORD_W-1:0]    s_tdata   = '0;   // data_word
    logic                           s_tuser   = bfce_pkg::CMD_COMPRESS;   // command
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bfce_pkg::WORD_W-1:0]    m_tdata;   // result_word
    logic                           m_tuser;   // result_valid

    // register copies as the block should hold them
    logic [bfce_pkg::VW_W-1:0]   width_reg = 7'd64;
    logic [bfce_pkg::WORD_W-1:0] mask_reg  = '0;
    logic [bfce_pkg::WORD_W-1:0] value_reg = '0;

    result_t awaited_results[$];
    int      errors    = 0;
    bit      tx_gaps_on = 1'b0;
    bit      rx_gaps_on = 1'b0;
    int      hold_req   = 0;

    always #4 aclk = ~aclk;

    bit_field_compress_expand_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic logic [bfce_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // significant, fixed and required-value masks for the current settings
    function automatic void field_masks(output logic [bfce_pkg::WORD_W-1:0] wm,
                                        output logic [bfce_pkg::WORD_W-1:0] fm,
                                        output logic [bfce_pkg::WORD_W-1:0] fv);
        int w;
        w = int'(width_reg);
        if (w > DATA_W) w = DATA_W;
        wm = (w >= bfce_pkg::WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
        fm = mask_reg & wm;
        fv = value_reg & fm;
    endfunction

    function automatic result_t compress_expand_result(
        input logic cmd, input logic [bfce_pkg::WORD_W-1:0] data);
        logic [bfce_pkg::WORD_W-1:0] wm, fm, fv, free_bits;
        result_t r;
        int k;
        field_masks(wm, fm, fv);
        free_bits = wm & ~fm;
        r = '0;
        k = 0;
        if (cmd == bfce_pkg::CMD_COMPRESS) begin
            if (((data & ~wm) == '0) && ((data & fm) == fv)) begin
                for (int i = 0; i < bfce_pkg::WORD_W; i++) begin
                    if (free_bits[i]) begin
                        r.word[k] = data[i];
                        k++;
                    end
                end
                r.flag = 1'b1;
            end
        end else begin
            for (int i = 0; i < bfce_pkg::WORD_W; i++) begin
                if (free_bits[i]) begin
                    r.word[i] = data[k];
                    k++;
                end
            end
            r.word = r.word | fv;
            r.flag = 1'b1;
        end
        return r;
    endfunction

    // pop on result, queue on accepted word; pop first so a stray result is caught
    always @(posedge aclk) begin : scoreboard
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.word) begin
                        $display("%0t: result_word mismatch: expected %h, actual %h",
                                 $time, want.word, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.flag) begin
                        $display("%0t: result_valid mismatch: expected %b, actual %b",
                                 $time, want.flag, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                                       compress_expand_result(s_tuser, s_tdata));
        end
    end

    // result side ready: random gaps per word, plus long hold-offs on request
    initial begin : sink
        int gap;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_req > 0) begin
                m_tready <= 1'b0;
                repeat (hold_req) @(posedge aclk);
                hold_req = 0;
                m_tready <= 1'b1;
            end else if (m_tvalid && m_tready && rx_gaps_on) begin
                gap = $urandom_range(0, 9);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [bfce_pkg::WORD_W-1:0] data);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result, then let the pipe drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic load_config(input logic [bfce_pkg::VW_W-1:0] width,
                               input logic [bfce_pkg::WORD_W-1:0] mask,
                               input logic [bfce_pkg::WORD_W-1:0] value);
        logic [bfce_pkg::WORD_W-1:0] junk;
        settle();
        junk = rand_word();
        cfg_wr_en <= 1'b1;
        cfg_index <= bfce_pkg::REG_VALUE_WIDTH;
        cfg_wdata <= {junk[bfce_pkg::WORD_W-1:bfce_pkg::VW_W], width};
        width_reg = width;
        @(posedge aclk);
        cfg_index <= bfce_pkg::REG_FIXED_MASK;
        cfg_wdata <= mask;
        mask_reg = mask;
        @(posedge aclk);
        cfg_index <= bfce_pkg::REG_FIXED_VALUE;
        cfg_wdata <= value;
        value_reg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_random_config();
        logic [bfce_pkg::VW_W-1:0] width;
        logic [bfce_pkg::WORD_W-1:0] mask;
        case ($urandom_range(0, 9))
            0: width = 7'd0;
            1: width = 7'd1;
            2: width = 7'd63;
            3: width = 7'd64;
            4: width = bfce_pkg::VW_W'($urandom_range(65, 127));
            default: width = bfce_pkg::VW_W'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 3))
            0: mask = '0;
            1: mask = '1;
            2: mask = rand_word() & rand_word();
            default: mask = rand_word();
        endcase
        load_config(width, mask, rand_word());
    endtask

    // expand words, words that pass the fixed-bit check, near misses and noise
    task automatic send_random_word();
        logic [bfce_pkg::WORD_W-1:0] wm, fm, fv, good;
        int pick;
        field_masks(wm, fm, fv);
        good = (rand_word() & wm & ~fm) | fv;
        pick = $urandom_range(0, 11);
        if (pick < 3)
            send_word(bfce_pkg::CMD_EXPAND, rand_word());
        else if (pick < 8)
            send_word(bfce_pkg::CMD_COMPRESS, good);
        else if (pick < 10)
            send_word(bfce_pkg::CMD_COMPRESS,
                      good ^ (64'd1 << $urandom_range(0, bfce_pkg::WORD_W - 1)));
        else
            send_word(bfce_pkg::CMD_COMPRESS, rand_word());
    endtask

    task automatic test_reset_settings();
        send_word(bfce_pkg::CMD_COMPRESS, '0);
        send_word(bfce_pkg::CMD_COMPRESS, '1);
        send_word(bfce_pkg::CMD_EXPAND, '1);
        send_word(bfce_pkg::CMD_EXPAND, rand_word());
    endtask

    task automatic test_directed_cases();
        logic [bfce_pkg::WORD_W-1:0] v;
        // zero width: only zero compresses
        load_config(7'd0, '1, '1);
        send_word(bfce_pkg::CMD_COMPRESS, '0);
        send_word(bfce_pkg::CMD_COMPRESS, 64'd1);
        send_word(bfce_pkg::CMD_EXPAND, '1);
        load_config(7'd1, '0, '1);
        send_word(bfce_pkg::CMD_COMPRESS, 64'd1);
        send_word(bfce_pkg::CMD_COMPRESS, 64'd2);
        send_word(bfce_pkg::CMD_EXPAND, '1);
        // every bit fixed
        v = rand_word();
        load_config(7'd64, '1, v);
        send_word(bfce_pkg::CMD_COMPRESS, v);
        send_word(bfce_pkg::CMD_COMPRESS, v ^ 64'h8000_0000_0000_0000);
        send_word(bfce_pkg::CMD_EXPAND, '1);
        // width above the data width, value bits outside the mask
        load_config(7'd127, 64'h0000_0000_0000_00F0, 64'h0000_0000_0000_00A5);
        send_word(bfce_pkg::CMD_COMPRESS, 64'hFFFF_FFFF_FFFF_FFAF);
        send_word(bfce_pkg::CMD_EXPAND, '1);
        load_config(7'd65, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
        send_word(bfce_pkg::CMD_COMPRESS, 64'h8000_0000_0000_1234);
        // mask beyond the width, spare compressed bits on expand
        load_config(7'd12, 64'hFFFF_0000_0000_0F00, '1);
        send_word(bfce_pkg::CMD_COMPRESS, 64'h0000_0000_0000_0F5A);
        send_word(bfce_pkg::CMD_COMPRESS, 64'h0000_0000_0000_1F5A);
        send_word(bfce_pkg::CMD_COMPRESS, 64'h0000_0000_0000_0E5A);
        send_word(bfce_pkg::CMD_EXPAND, '1);
        // unmapped index must leave the settings alone
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_wdata <= rand_word();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_word(bfce_pkg::CMD_COMPRESS, 64'h0000_0000_0000_0F5A);
        send_word(bfce_pkg::CMD_EXPAND, 64'h0000_0000_0000_00FF);
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 7; ph++) begin
            load_random_config();
            tx_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
            rx_gaps_on = (ph % 4 == 0) || (ph % 4 == 3);
            repeat (110) send_random_word();
        end
    endtask

    task automatic test_backpressure();
        load_random_config();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_req   = 300;
        repeat (80) send_random_word();
        settle();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (60) send_random_word();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_directed_cases();
        test_random_traffic();
        test_backpressure();
        settle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
